// File: design/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg
// Shared constant and index helper for the orthonormal basis builder.
// ----------------------------------------------------------------------------
package obb_pkg;

	localparam int unsigned NUM_AXES = 3;

	// Axis that follows axis i by n places (x -> y -> z -> x).
	function automatic int unsigned ax_next(int unsigned i, int unsigned n);
		return (i + n) % NUM_AXES;
	endfunction

endpackage

// File: design/obb_norm.sv
// ----------------------------------------------------------------------------
// obb_norm
// Pipelined normalizer: sum of squares, one root bit per stage, then one
// quotient bit per stage for each axis. Sideband bits travel with the request.
// ----------------------------------------------------------------------------
module obb_norm
	import obb_pkg::*;
#(
	parameter int W  = 32,
	parameter int FB = 16,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [W-1:0]  mag [NUM_AXES],
	input  logic [PW-1:0] side_in,
	output logic          out_vld,
	output logic [FB:0]   quo [NUM_AXES],
	output logic [PW-1:0] side_out
);

	localparam int H   = (W + 1) / 2;
	localparam int HW  = W - H;
	localparam int SW  = 2 * W + 2;
	localparam int RW  = W + 1;
	localparam int NW  = W + FB + 1;
	localparam int QW  = FB + 1;
	localparam int LAT = 2 + RW + QW;

	logic [LAT:1]       vld_s;
	logic [PW-1:0]      side_s [1:LAT];

	logic [2*HW-1:0]    hh_s1 [NUM_AXES];
	logic [W-1:0]       hl_s1 [NUM_AXES];
	logic [2*H-1:0]     ll_s1 [NUM_AXES];
	logic [W-1:0]       m_s1  [NUM_AXES];

	logic [SW-1:0]      sq_sum;
	logic [SW-1:0]      sum_s2;
	logic [W-1:0]       m_s2 [NUM_AXES];

	logic [SW-1:0]      srem_s  [1:RW];
	logic [RW-1:0]      sroot_s [1:RW];
	logic [W-1:0]       smag_s  [1:RW][NUM_AXES];

	logic [NW-1:0]      drem_s [1:QW][NUM_AXES];
	logic [QW-1:0]      quo_s  [1:QW][NUM_AXES];
	logic [RW-1:0]      dsor_s [1:QW];

	// valid and sideband shift line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-1:1], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= side_in;
			for (int n = 2; n <= LAT; n++) begin
				side_s[n] <= side_s[n-1];
			end
		end
	end

	// split squares into half-width partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				hh_s1[i] <= mag[i][W-1:H] * mag[i][W-1:H];
				hl_s1[i] <= mag[i][W-1:H] * mag[i][H-1:0];
				ll_s1[i] <= mag[i][H-1:0] * mag[i][H-1:0];
				m_s1[i]  <= mag[i];
			end
		end
	end

	always_comb begin
		sq_sum = '0;
		for (int i = 0; i < NUM_AXES; i++) begin
			sq_sum = sq_sum + (SW'(hh_s1[i]) << (2 * H)) + (SW'(hl_s1[i]) << (H + 1))
				+ SW'(ll_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sq_sum;
			m_s2   <= m_s1;
		end
	end

	// square root, one result bit per stage, most significant first
	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		localparam int B = RW - 1 - k;
		logic [SW-1:0] rem_in;
		logic [RW-1:0] root_in;
		logic [W-1:0]  mag_in [NUM_AXES];
		logic [SW-1:0] trial;

		if (k == 0) begin : g_first
			assign rem_in  = sum_s2;
			assign root_in = '0;
			assign mag_in  = m_s2;
		end else begin : g_next
			assign rem_in  = srem_s[k];
			assign root_in = sroot_s[k];
			assign mag_in  = smag_s[k];
		end

		assign trial = (SW'(root_in) << (B + 1)) + (SW'(1) << (2 * B));

		always_ff @(posedge clk) begin
			if (en) begin
				smag_s[k+1] <= mag_in;
				if (rem_in >= trial) begin
					srem_s[k+1]  <= rem_in - trial;
					sroot_s[k+1] <= root_in | (RW'(1) << B);
				end else begin
					srem_s[k+1]  <= rem_in;
					sroot_s[k+1] <= root_in;
				end
			end
		end
	end

	// restoring divide of (mag << FB) by the root, one quotient bit per stage
	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int B = QW - 1 - j;
		logic [RW-1:0] dsor_in;
		logic [NW-1:0] rem_in [NUM_AXES];
		logic [QW-1:0] q_in   [NUM_AXES];
		logic [NW-1:0] dtrial;

		if (j == 0) begin : g_first
			assign dsor_in = sroot_s[RW];
			always_comb begin
				for (int i = 0; i < NUM_AXES; i++) begin
					rem_in[i] = NW'(smag_s[RW][i]) << FB;
					q_in[i]   = '0;
				end
			end
		end else begin : g_next
			assign dsor_in = dsor_s[j];
			assign rem_in  = drem_s[j];
			assign q_in    = quo_s[j];
		end

		assign dtrial = NW'(dsor_in) << B;

		always_ff @(posedge clk) begin
			if (en) begin
				dsor_s[j+1] <= dsor_in;
				for (int i = 0; i < NUM_AXES; i++) begin
					if (rem_in[i] >= dtrial) begin
						drem_s[j+1][i] <= rem_in[i] - dtrial;
						quo_s[j+1][i]  <= q_in[i] | (QW'(1) << B);
					end else begin
						drem_s[j+1][i] <= rem_in[i];
						quo_s[j+1][i]  <= q_in[i];
					end
				end
			end
		end
	end

	// a zero vector has a zero root: drop the quotient, components are zero
	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			quo[i] = (dsor_s[QW] == '0) ? '0 : quo_s[QW][i];
		end
	end

	assign out_vld  = vld_s[LAT];
	assign side_out = side_s[LAT];

endmodule

// File: design/orthonormal_basis_builder.sv
// ----------------------------------------------------------------------------
// orthonormal_basis_builder
// Builds an orthonormal basis from two signed fixed-point 3-vectors.
// ----------------------------------------------------------------------------
// The block takes one request (vectors a and b) per clock while in_stall is
// low, and returns one result per request, in order. Unit a is a scaled by
// 2^FRACTION_BITS over floor(sqrt(|a|^2)), truncated toward zero; c is
// unit_a x b, normalized the same way; ortho_b is (c x unit_a) shifted down
// by FRACTION_BITS toward zero. When c is exactly zero (a zero, or a and b
// parallel) success is low, c reads zero and b is passed through. The
// defaults give Q16.16 in 32 bits. The pipeline is built around the two
// normalizers, each of which resolves one square-root bit and then one
// quotient bit per stage. A stall on the result side while a result is
// waiting freezes the whole pipeline and raises in_stall in the same cycle;
// nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module orthonormal_basis_builder
	import obb_pkg::*;
#(
	parameter int COMPONENT_WIDTH = 32,
	parameter int FRACTION_BITS   = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [COMPONENT_WIDTH-1:0] a_x,
	input  logic signed [COMPONENT_WIDTH-1:0] a_y,
	input  logic signed [COMPONENT_WIDTH-1:0] a_z,
	input  logic signed [COMPONENT_WIDTH-1:0] b_x,
	input  logic signed [COMPONENT_WIDTH-1:0] b_y,
	input  logic signed [COMPONENT_WIDTH-1:0] b_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [FRACTION_BITS+1:0]   unit_a_x,
	output logic signed [FRACTION_BITS+1:0]   unit_a_y,
	output logic signed [FRACTION_BITS+1:0]   unit_a_z,
	output logic signed [COMPONENT_WIDTH-1:0] ortho_b_x,
	output logic signed [COMPONENT_WIDTH-1:0] ortho_b_y,
	output logic signed [COMPONENT_WIDTH-1:0] ortho_b_z,
	output logic signed [FRACTION_BITS+1:0]   normal_c_x,
	output logic signed [FRACTION_BITS+1:0]   normal_c_y,
	output logic signed [FRACTION_BITS+1:0]   normal_c_z,
	output logic                              success
);

	localparam int CW  = COMPONENT_WIDTH;
	localparam int FB  = FRACTION_BITS;
	localparam int UW  = FB + 2;            // signed unit component
	localparam int PCW = UW + CW;           // unit x b product
	localparam int CCW = PCW + 1;           // cross component of unit a and b
	localparam int CM  = FB + CW + 1;       // magnitude of that component
	localparam int PDW = 2 * UW;            // unit x unit product
	localparam int DW  = PDW + 1;           // cross component of two unit vectors
	localparam int XW  = ((DW > CW) ? DW : CW) + 1;
	localparam int PWA = NUM_AXES + NUM_AXES * CW;
	localparam int PWC = 1 + NUM_AXES + NUM_AXES * UW + NUM_AXES * CW;

	// Advance everything unless a finished result is held off.
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// ---------------------------------------------------------------- input
	logic signed [CW-1:0] a_v [NUM_AXES];
	logic signed [CW-1:0] b_v [NUM_AXES];
	logic        [CW-1:0] a_mag [NUM_AXES];
	logic [PWA-1:0]       side_a_in;

	assign a_v[0] = a_x;
	assign a_v[1] = a_y;
	assign a_v[2] = a_z;
	assign b_v[0] = b_x;
	assign b_v[1] = b_y;
	assign b_v[2] = b_z;

	for (genvar i = 0; i < NUM_AXES; i++) begin : g_in
		// the most negative value maps onto its own bit pattern, read unsigned
		assign a_mag[i]                    = a_v[i][CW-1] ? CW'(-a_v[i]) : CW'(a_v[i]);
		assign side_a_in[i*CW +: CW]       = b_v[i];
		assign side_a_in[NUM_AXES*CW + i]  = a_v[i][CW-1];
	end

	logic                 na_vld;
	logic [FB:0]          qa [NUM_AXES];
	logic [PWA-1:0]       side_a_out;

	obb_norm #(
		.W  (CW),
		.FB (FB),
		.PW (PWA)
	) u_norm_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (in_valid),
		.mag      (a_mag),
		.side_in  (side_a_in),
		.out_vld  (na_vld),
		.quo      (qa),
		.side_out (side_a_out)
	);

	// ------------------------------------------------- c = unit_a x b
	logic                  vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [UW-1:0]  ua_s1 [NUM_AXES];
	logic signed [CW-1:0]  b_s1  [NUM_AXES];
	logic signed [PCW-1:0] pc0_s2 [NUM_AXES];
	logic signed [PCW-1:0] pc1_s2 [NUM_AXES];
	logic signed [UW-1:0]  ua_s2 [NUM_AXES];
	logic signed [CW-1:0]  b_s2  [NUM_AXES];
	logic signed [CCW-1:0] c_s3  [NUM_AXES];
	logic signed [UW-1:0]  ua_s3 [NUM_AXES];
	logic signed [CW-1:0]  b_s3  [NUM_AXES];
	logic signed [CCW-1:0] c_abs [NUM_AXES];
	logic        [CM-1:0]  cmag_s4 [NUM_AXES];
	logic [PWC-1:0]        side_c_d;
	logic [PWC-1:0]        side_c_s4;
	logic                  c_nz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= na_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_comb begin
		c_nz = 1'b0;
		for (int i = 0; i < NUM_AXES; i++) begin
			c_nz = c_nz || (c_s3[i] != '0);
		end
	end

	for (genvar i = 0; i < NUM_AXES; i++) begin : g_cross_c
		localparam int unsigned J = ax_next(i, 1);
		localparam int unsigned K = ax_next(i, 2);

		assign c_abs[i] = c_s3[i][CCW-1] ? -c_s3[i] : c_s3[i];

		// pack b, unit a and the sign of c for the second normalizer
		assign side_c_d[i*CW +: CW]               = b_s3[i];
		assign side_c_d[NUM_AXES*CW + i*UW +: UW] = ua_s3[i];
		assign side_c_d[NUM_AXES*(CW+UW) + i]     = c_s3[i][CCW-1];

		always_ff @(posedge clk) begin
			if (en) begin
				// re-sign the unit component
				ua_s1[i] <= side_a_out[NUM_AXES*CW + i] ? -$signed({1'b0, qa[i]})
					: $signed({1'b0, qa[i]});
				b_s1[i]  <= $signed(side_a_out[i*CW +: CW]);

				pc0_s2[i] <= ua_s1[J] * b_s1[K];
				pc1_s2[i] <= ua_s1[K] * b_s1[J];
				ua_s2[i]  <= ua_s1[i];
				b_s2[i]   <= b_s1[i];

				c_s3[i]   <= pc0_s2[i] - pc1_s2[i];
				ua_s3[i]  <= ua_s2[i];
				b_s3[i]   <= b_s2[i];

				cmag_s4[i] <= c_abs[i][CM-1:0];
			end
		end
	end

	assign side_c_d[PWC-1] = c_nz;

	always_ff @(posedge clk) begin
		if (en) begin
			side_c_s4 <= side_c_d;
		end
	end

	logic                 nc_vld;
	logic [FB:0]          qc [NUM_AXES];
	logic [PWC-1:0]       side_c_out;

	obb_norm #(
		.W  (CM),
		.FB (FB),
		.PW (PWC)
	) u_norm_c (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.mag      (cmag_s4),
		.side_in  (side_c_s4),
		.out_vld  (nc_vld),
		.quo      (qc),
		.side_out (side_c_out)
	);

	// ------------------------------------------ ortho_b = unit_c x unit_a
	logic                  vld_s5, vld_s6, vld_s7, vld_s8;
	logic                  ok_s5, ok_s6, ok_s7, ok_s8;
	logic signed [UW-1:0]  uc_s5 [NUM_AXES];
	logic signed [UW-1:0]  ua_s5 [NUM_AXES];
	logic signed [CW-1:0]  b_s5  [NUM_AXES];
	logic signed [PDW-1:0] pd0_s6 [NUM_AXES];
	logic signed [PDW-1:0] pd1_s6 [NUM_AXES];
	logic signed [UW-1:0]  uc_s6 [NUM_AXES];
	logic signed [UW-1:0]  ua_s6 [NUM_AXES];
	logic signed [CW-1:0]  b_s6  [NUM_AXES];
	logic signed [DW-1:0]  d_s7  [NUM_AXES];
	logic signed [UW-1:0]  uc_s7 [NUM_AXES];
	logic signed [UW-1:0]  ua_s7 [NUM_AXES];
	logic signed [CW-1:0]  b_s7  [NUM_AXES];
	logic signed [UW-1:0]  uc_s8 [NUM_AXES];
	logic signed [UW-1:0]  ua_s8 [NUM_AXES];
	logic signed [CW-1:0]  nb_s8 [NUM_AXES];
	logic        [DW-1:0]  d_abs [NUM_AXES];
	logic        [XW-1:0]  d_shx [NUM_AXES];
	logic        [XW-1:0]  d_lim [NUM_AXES];
	logic signed [CW-1:0]  nb_d  [NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s5 <= nc_vld;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s5 <= side_c_out[PWC-1];
			ok_s6 <= ok_s5;
			ok_s7 <= ok_s6;
			ok_s8 <= ok_s7;
		end
	end

	for (genvar i = 0; i < NUM_AXES; i++) begin : g_cross_b
		localparam int unsigned J = ax_next(i, 1);
		localparam int unsigned K = ax_next(i, 2);

		// truncate toward zero on the magnitude, then clamp to the output range
		assign d_abs[i] = d_s7[i][DW-1] ? DW'(-d_s7[i]) : DW'(d_s7[i]);
		assign d_shx[i] = XW'(d_abs[i] >> FB);

		always_comb begin
			if (d_s7[i][DW-1]) begin
				d_lim[i] = (d_shx[i] > (XW'(1) << (CW - 1))) ? (XW'(1) << (CW - 1)) : d_shx[i];
				nb_d[i]  = $signed(CW'(-d_lim[i]));
			end else begin
				d_lim[i] = (d_shx[i] > ((XW'(1) << (CW - 1)) - XW'(1)))
					? ((XW'(1) << (CW - 1)) - XW'(1)) : d_shx[i];
				nb_d[i]  = $signed(CW'(d_lim[i]));
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				uc_s5[i] <= side_c_out[NUM_AXES*(CW+UW) + i] ? -$signed({1'b0, qc[i]})
					: $signed({1'b0, qc[i]});
				ua_s5[i] <= $signed(side_c_out[NUM_AXES*CW + i*UW +: UW]);
				b_s5[i]  <= $signed(side_c_out[i*CW +: CW]);

				pd0_s6[i] <= uc_s5[J] * ua_s5[K];
				pd1_s6[i] <= uc_s5[K] * ua_s5[J];
				uc_s6[i]  <= uc_s5[i];
				ua_s6[i]  <= ua_s5[i];
				b_s6[i]   <= b_s5[i];

				d_s7[i]  <= pd0_s6[i] - pd1_s6[i];
				uc_s7[i] <= uc_s6[i];
				ua_s7[i] <= ua_s6[i];
				b_s7[i]  <= b_s6[i];

				// on failure hand b back and zero c
				uc_s8[i] <= ok_s7 ? uc_s7[i] : '0;
				ua_s8[i] <= ua_s7[i];
				nb_s8[i] <= ok_s7 ? nb_d[i] : b_s7[i];
			end
		end
	end

	// ---------------------------------------------------------------- output
	assign out_valid  = vld_s8;
	assign success    = ok_s8;
	assign unit_a_x   = ua_s8[0];
	assign unit_a_y   = ua_s8[1];
	assign unit_a_z   = ua_s8[2];
	assign ortho_b_x  = nb_s8[0];
	assign ortho_b_y  = nb_s8[1];
	assign ortho_b_z  = nb_s8[2];
	assign normal_c_x = uc_s8[0];
	assign normal_c_y = uc_s8[1];
	assign normal_c_z = uc_s8[2];

	// a failed build must report a zero normal
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !success |-> normal_c_x == '0 && normal_c_y == '0 && normal_c_z == '0)
		else $error("failed build with nonzero normal");

	// a successful build has a nonzero normal
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && success |-> normal_c_x != '0 || normal_c_y != '0 || normal_c_z != '0)
		else $error("successful build with zero normal");

	// a zero unit a cannot give a basis
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unit_a_x == '0 && unit_a_y == '0 && unit_a_z == '0 |-> !success)
		else $error("success reported for zero vector a");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for orthonormal_basis_builder: drives vector pairs with
// random gaps, stalls the result side at random, and checks every result
// against a wide-integer predictor of the normalize / cross-product chain.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam int UW = FB + 2;
	localparam int PIPE_DEPTH = 8 + (FB + CW + 4) + (FB + CW + FB + 1 + 4);

	typedef logic signed [255:0] wide_t;

	typedef struct packed {
		logic signed [CW-1:0] ax, ay, az, bx, by, bz;
	} vec_pair_t;

	typedef struct packed {
		logic signed [UW-1:0] ua_x, ua_y, ua_z;
		logic signed [CW-1:0] ob_x, ob_y, ob_z;
		logic signed [UW-1:0] nc_x, nc_y, nc_z;
		logic                 ok;
	} basis_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CW-1:0] a_x = '0, a_y = '0, a_z = '0, b_x = '0, b_y = '0, b_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [UW-1:0] unit_a_x, unit_a_y, unit_a_z;
	logic signed [CW-1:0] ortho_b_x, ortho_b_y, ortho_b_z;
	logic signed [UW-1:0] normal_c_x, normal_c_y, normal_c_z;
	logic success;

	basis_t expected_bases[$];
	int mismatches = 0;
	bit stall_enable = 1'b1;
	int stall_left = 0;

	orthonormal_basis_builder #(.COMPONENT_WIDTH(CW), .FRACTION_BITS(FB)) i_dut (
		.clk, .arst_n, .in_valid, .in_stall,
		.a_x, .a_y, .a_z, .b_x, .b_y, .b_z,
		.out_valid, .out_stall,
		.unit_a_x, .unit_a_y, .unit_a_z,
		.ortho_b_x, .ortho_b_y, .ortho_b_z,
		.normal_c_x, .normal_c_y, .normal_c_z,
		.success
	);

	always #10 clk = ~clk;

	// Integer square root, floor. Magnitudes here stay far below 2^128.
	function automatic wide_t floor_sqrt(wide_t s);
		wide_t r, c;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			c = r | (wide_t'(1) <<< i);
			if (c * c <= s)
				r = c;
		end
		return r;
	endfunction

	// Scale by 2^FB over floor(|v|); signed division truncates toward zero.
	function automatic void unitize(inout wide_t v[3]);
		wide_t mag;
		mag = floor_sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
		if (mag != 0)
			for (int i = 0; i < 3; i++)
				v[i] = (v[i] <<< FB) / mag;
	endfunction

	function automatic void cross3(input wide_t u[3], input wide_t w[3], output wide_t r[3]);
		r[0] = u[1] * w[2] - u[2] * w[1];
		r[1] = u[2] * w[0] - u[0] * w[2];
		r[2] = u[0] * w[1] - u[1] * w[0];
	endfunction

	function automatic basis_t build_basis(vec_pair_t p);
		wide_t a[3], b[3], c[3], nb[3];
		basis_t r;
		a[0] = p.ax; a[1] = p.ay; a[2] = p.az;
		b[0] = p.bx; b[1] = p.by; b[2] = p.bz;
		unitize(a);
		cross3(a, b, c);
		r.ok = (c[0] != 0) || (c[1] != 0) || (c[2] != 0);
		if (r.ok) begin
			unitize(c);
			cross3(c, a, nb);
			for (int i = 0; i < 3; i++)
				nb[i] = nb[i] / (wide_t'(1) <<< FB);
		end else begin
			nb = b;
			c[0] = 0; c[1] = 0; c[2] = 0;
		end
		r.ua_x = a[0]; r.ua_y = a[1]; r.ua_z = a[2];
		r.ob_x = nb[0]; r.ob_y = nb[1]; r.ob_z = nb[2];
		r.nc_x = c[0]; r.nc_y = c[1]; r.nc_z = c[2];
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Present one request, hold it until accepted, then idle for a random gap.
	// Valid stays high across back-to-back requests.
	task automatic send_pair(vec_pair_t p, int gap);
		@(negedge clk);
		in_valid = 1'b1;
		a_x = p.ax; a_y = p.ay; a_z = p.az;
		b_x = p.bx; b_y = p.by; b_z = p.bz;
		do @(posedge clk); while (in_stall);
		expected_bases.push_back(build_basis(p));
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic logic signed [CW-1:0] rnd_comp();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 255) - 128;
			1: return $signed($urandom) >>> $urandom_range(0, 30);
			2: return {1'b1, {(CW-1){1'b0}}};
			default: return $urandom;
		endcase
	endfunction

	function automatic vec_pair_t rnd_pair();
		vec_pair_t p;
		int k;
		p.ax = rnd_comp(); p.ay = rnd_comp(); p.az = rnd_comp();
		p.bx = rnd_comp(); p.by = rnd_comp(); p.bz = rnd_comp();
		case ($urandom_range(0, 9))
			0: begin
				// b parallel to a: scale a small vector
				k = $urandom_range(0, 8) - 4;
				p.ax = $signed($urandom) >>> 4;
				p.ay = $signed($urandom) >>> 4;
				p.az = $signed($urandom) >>> 4;
				p.bx = p.ax * k; p.by = p.ay * k; p.bz = p.az * k;
			end
			1: begin
				p.ax = '0; p.ay = '0; p.az = '0;
			end
			2: p.ay = '0;
			default: ;
		endcase
		return p;
	endfunction

	// Compare one field; report the first few mismatches, count the rest.
	function automatic void check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %0d, got %0d", name, exp_v, act_v);
		end
	endfunction

	// Result side: random stall, most stretches short, a few long, some none.
	always @(negedge clk) begin
		if (!stall_enable) begin
			stall_left <= 0;
			out_stall  <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if ($urandom_range(0, 99) < 2) begin
			stall_left <= $urandom_range(10, 40);
			out_stall  <= 1'b1;
		end else begin
			out_stall  <= ($urandom_range(0, 99) < 20);
		end
	end

	// Check each accepted result against the oldest expected basis.
	always @(posedge clk) begin
		basis_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bases.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with no request outstanding");
			end else begin
				e = expected_bases.pop_front();
				check_field("unit_a_x", e.ua_x, unit_a_x);
				check_field("unit_a_y", e.ua_y, unit_a_y);
				check_field("unit_a_z", e.ua_z, unit_a_z);
				check_field("ortho_b_x", e.ob_x, ortho_b_x);
				check_field("ortho_b_y", e.ob_y, ortho_b_y);
				check_field("ortho_b_z", e.ob_z, ortho_b_z);
				check_field("normal_c_x", e.nc_x, normal_c_x);
				check_field("normal_c_y", e.nc_y, normal_c_y);
				check_field("normal_c_z", e.nc_z, normal_c_z);
				check_field("success", e.ok, success);
			end
		end
	end

	task automatic test_corner_vectors();
		localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
		localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};
		localparam logic signed [CW-1:0] ONE = 1 << FB;
		// zero a: unit_a zero, failure
		send_pair('{0, 0, 0, ONE, 2, 3}, 0);
		// both zero
		send_pair('{0, 0, 0, 0, 0, 0}, 1);
		// parallel and anti-parallel
		send_pair('{ONE, 0, 0, 5 * ONE, 0, 0}, 0);
		send_pair('{3, -4, 12, -6, 8, -24}, 0);
		// zero b
		send_pair('{ONE, ONE, 0, 0, 0, 0}, 2);
		// orthogonal axes
		send_pair('{ONE, 0, 0, 0, ONE, 0}, 0);
		send_pair('{0, 0, -ONE, ONE, 0, 0}, 0);
		// extremes of every field
		send_pair('{MAXV, MAXV, MAXV, MINV, MINV, MINV}, 0);
		send_pair('{MINV, MINV, MINV, MAXV, MAXV, MAXV}, 0);
		send_pair('{MINV, 0, 0, 0, MINV, 0}, 0);
		send_pair('{MAXV, MINV, 1, -1, MAXV, MINV}, 0);
		send_pair('{1, 0, 0, 0, 0, 1}, 0);
		send_pair('{-1, -1, -1, 1, 0, -1}, 3);
		send_pair('{1, 1, 0, MAXV, MINV, MAXV}, 0);
	endtask

	task automatic test_random_pairs(int count);
		for (int n = 0; n < count; n++)
			send_pair(rnd_pair(), pick_gap());
	endtask

	// Hold off the sender until the pipeline has drained, then send a burst
	// with no idling on either side.
	task automatic test_drain_and_burst();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_bases.size() != 0) @(posedge clk);
		stall_enable = 1'b0;
		for (int n = 0; n < 200; n++)
			send_pair(rnd_pair(), 0);
		stall_enable = 1'b1;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_corner_vectors();
		test_random_pairs(900);
		test_drain_and_burst();
		test_random_pairs(900);
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_bases.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 20) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

endmodule
